/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files of the key press event detector.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KPED_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication.
`define KPED_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* rtl/kped_pkg.sv */
// Shared types and constants for the key press event detector.
// No dependencies; used by every module of the block.
`default_nettype none

package kped_pkg;

    localparam int NUM_KEYS_DEF  = 5;
    localparam int COUNT_MAX_DEF = 255;
    localparam int CFG_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int KIND_W        = 2;

    typedef logic [CFG_W-1:0] cfg_word_t;

    localparam cfg_word_t LONG_RESET     = 8'd50;
    localparam cfg_word_t REPEAT_RESET   = 8'd10;
    localparam cfg_word_t DEBOUNCE_RESET = 8'd2;

    typedef enum logic [KIND_W-1:0] {
        EV_DOWN = 2'd0,
        EV_UP   = 2'd1,
        EV_LONG = 2'd2
    } event_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LONG     = 2'd0,
        REG_REPEAT   = 2'd1,
        REG_DEBOUNCE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        cfg_word_t long_polls;
        cfg_word_t repeat_polls;
        cfg_word_t debounce_polls;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic step;
    } lane_ctrl_t;

    typedef struct packed {
        logic ev_a;
        logic a_long;
        logic ev_down;
    } lane_res_t;

endpackage

`default_nettype wire

/* rtl/kped_lane.sv */
// One key lane: hold counter, release check and bit-serial repeat remainder.
// Depends on kped_pkg.
`default_nettype none

module kped_lane #(
    parameter int COUNT_MAX = kped_pkg::COUNT_MAX_DEF
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire kped_pkg::lane_ctrl_t ctrl,
    input  wire kped_pkg::cfg_t      cfg,
    input  wire                      pressed,
    input  wire                      newly,
    output kped_pkg::lane_res_t      res
);

    localparam int CW = $clog2(COUNT_MAX + 1);
    localparam int DW = (CW > kped_pkg::CFG_W) ? CW : kped_pkg::CFG_W;
    localparam int RW = kped_pkg::CFG_W;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] dvd_reg, dvd_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic          pressed_reg, pressed_next;
    logic          newly_reg, newly_next;
    logic          eq_reg, eq_next;
    logic          div_en_reg, div_en_next;
    logic          up_reg, up_next;

    logic [CW-1:0] count_inc;
    logic [DW-1:0] c_ext, long_ext, old_ext, deb_ext, diff;
    logic [RW:0]   trial, rep_ext;
    logic [RW-1:0] rem_step;

    always_comb
    begin
        count_inc = (count_reg == CW'(COUNT_MAX)) ? count_reg : count_reg + 1'b1;
        c_ext     = DW'(count_inc);
        long_ext  = DW'(cfg.long_polls);
        old_ext   = DW'(count_reg);
        deb_ext   = DW'(cfg.debounce_polls);
        diff      = c_ext - long_ext;
        trial     = {rem_reg, dvd_reg[CW-1]};
        rep_ext   = {1'b0, cfg.repeat_polls};
        rem_step  = (trial >= rep_ext) ? RW'(trial - rep_ext) : trial[RW-1:0];
    end

    always_comb
    begin
        count_next   = count_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        pressed_next = pressed_reg;
        newly_next   = newly_reg;
        eq_next      = eq_reg;
        div_en_next  = div_en_reg;
        up_next      = up_reg;
        if (ctrl.start)
        begin
            pressed_next = pressed;
            newly_next   = newly;
            rem_next     = '0;
            if (pressed)
            begin
                count_next  = count_inc;
                eq_next     = (c_ext == long_ext);
                div_en_next = (c_ext > long_ext) && (cfg.repeat_polls != '0);
                dvd_next    = diff[CW-1:0];
                up_next     = 1'b0;
            end
            else
            begin
                count_next  = '0;
                eq_next     = 1'b0;
                div_en_next = 1'b0;
                dvd_next    = '0;
                up_next     = (old_ext >= deb_ext);
            end
        end
        else if (ctrl.step)
        begin
            rem_next = rem_step;
            dvd_next = dvd_reg << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pressed_reg <= 1'b0;
            newly_reg   <= 1'b0;
            eq_reg      <= 1'b0;
            div_en_reg  <= 1'b0;
            up_reg      <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            pressed_reg <= pressed_next;
            newly_reg   <= newly_next;
            eq_reg      <= eq_next;
            div_en_reg  <= div_en_next;
            up_reg      <= up_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        res.ev_a    = pressed_reg ? (eq_reg || (div_en_reg && (rem_reg == '0))) : up_reg;
        res.a_long  = pressed_reg;
        res.ev_down = newly_reg;
    end

endmodule

`default_nettype wire

/* rtl/kped_merge.sv */
// Merging stage: collects lane events into a pending mask and issues them in key order.
// Depends on kped_pkg.
`default_nettype none

module kped_merge #(
    parameter int NUM_KEYS = kped_pkg::NUM_KEYS_DEF,
    localparam int KIW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          load,
    input  wire kped_pkg::lane_res_t     lane_res [NUM_KEYS],
    output logic                         busy,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [KIW-1:0]               key_index,
    output logic [kped_pkg::KIND_W-1:0]  event_kind,
    output logic                         last_event
);

    localparam int NS = 2 * NUM_KEYS;
    localparam int SW = KIW + 1;

    logic [NS-1:0]               mask_reg, mask_next;
    logic [NUM_KEYS-1:0]         long_reg, long_next;
    logic                        out_valid_reg, out_valid_next;
    logic [KIW-1:0]              key_reg, key_next;
    logic [kped_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic                        last_reg, last_next;

    logic [NS-1:0]    pick;
    logic [NS-1:0]    load_mask;
    logic [NUM_KEYS-1:0] load_long;
    logic [SW-1:0]    slot;
    logic [KIW-1:0]   slot_key;
    logic             take;

    always_comb
    begin
        pick = mask_reg & (~mask_reg + 1'b1);
        slot = '0;
        for (int j = 0; j < NS; j++)
        begin
            if (pick[j])
            begin
                slot = slot | SW'(j);
            end
        end
        slot_key = slot[SW-1:1];
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            load_mask[2*k]   = lane_res[k].ev_a;
            load_mask[2*k+1] = lane_res[k].ev_down;
            load_long[k]     = lane_res[k].a_long;
        end
        take = (mask_reg != '0) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        mask_next      = mask_reg;
        long_next      = long_reg;
        out_valid_next = out_valid_reg;
        key_next       = key_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        if (load)
        begin
            mask_next = load_mask;
            long_next = load_long;
        end
        else if (take)
        begin
            mask_next = mask_reg & ~pick;
        end
        if (take)
        begin
            out_valid_next = 1'b1;
            key_next       = slot_key;
            last_next      = ((mask_reg & ~pick) == '0);
            if (slot[0])
            begin
                kind_next = kped_pkg::EV_DOWN;
            end
            else if (long_reg[slot_key])
            begin
                kind_next = kped_pkg::EV_LONG;
            end
            else
            begin
                kind_next = kped_pkg::EV_UP;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        long_reg <= long_next;
        key_reg  <= key_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign busy       = |mask_reg;
    assign out_valid  = out_valid_reg;
    assign key_index  = key_reg;
    assign event_kind = kind_reg;
    assign last_event = last_reg;

endmodule

`default_nettype wire

/* rtl/key_press_event_detector.sv */
// A poll is latched into the lanes; ST_DIV then runs the repeat remainder one bit per cycle
// in each lane (CW = bits of the hold counter, 8 at COUNT_MAX 255), and ST_LOAD moves the
// events into the pending mask. They leave the single output port one per cycle while
// out_ready is high; a new poll is taken only in ST_IDLE with the pending mask empty.
// Reset clears hold counters, previous keys and pending events; registers go to 50, 10, 2.
// Depends on kped_pkg, kped_lane and kped_merge.
`default_nettype none

module key_press_event_detector #(
    parameter int NUM_KEYS  = kped_pkg::NUM_KEYS_DEF,
    parameter int COUNT_MAX = kped_pkg::COUNT_MAX_DEF,
    localparam int KIW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_we,
    input  wire  [kped_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [kped_pkg::CFG_W-1:0]      cfg_data,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire  [NUM_KEYS-1:0]             keys_pressed,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [KIW-1:0]                  key_index,
    output logic [kped_pkg::KIND_W-1:0]     event_kind,
    output logic                            last_event
);

    localparam int CW    = $clog2(COUNT_MAX + 1);
    localparam int CNT_W = $clog2(CW + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       step_reg, step_next;
    logic [NUM_KEYS-1:0]    prev_reg, prev_next;
    kped_pkg::cfg_t         cfg_reg, cfg_next;

    logic                   accept;
    logic                   merge_busy;
    logic [NUM_KEYS-1:0]    newly;
    kped_pkg::lane_ctrl_t   lane_ctrl;
    kped_pkg::lane_res_t    lane_res [NUM_KEYS];

    assign in_ready = (state_reg == ST_IDLE) && !merge_busy;
    assign accept   = in_valid && in_ready;
    assign newly    = keys_pressed & ~prev_reg;

    always_comb
    begin
        lane_ctrl.start = accept;
        lane_ctrl.step  = (state_reg == ST_DIV);
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                kped_pkg::REG_LONG:     cfg_next.long_polls     = cfg_data;
                kped_pkg::REG_REPEAT:   cfg_next.repeat_polls   = cfg_data;
                kped_pkg::REG_DEBOUNCE: cfg_next.debounce_polls = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        prev_next  = accept ? keys_pressed : prev_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV;
                    step_next  = '0;
                end
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == CNT_W'(CW - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg              <= ST_IDLE;
            step_reg               <= '0;
            prev_reg               <= '0;
            cfg_reg.long_polls     <= kped_pkg::LONG_RESET;
            cfg_reg.repeat_polls   <= kped_pkg::REPEAT_RESET;
            cfg_reg.debounce_polls <= kped_pkg::DEBOUNCE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            prev_reg  <= prev_next;
            cfg_reg   <= cfg_next;
        end
    end

    for (genvar g = 0; g < NUM_KEYS; g++)
    begin : g_lane
        kped_lane #(
            .COUNT_MAX (COUNT_MAX)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (lane_ctrl),
            .cfg     (cfg_reg),
            .pressed (keys_pressed[g]),
            .newly   (newly[g]),
            .res     (lane_res[g])
        );
    end

    kped_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (state_reg == ST_LOAD),
        .lane_res   (lane_res),
        .busy       (merge_busy),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key_index  (key_index),
        .event_kind (event_kind),
        .last_event (last_event)
    );

endmodule

`default_nettype wire

/* rtl/kped_checker.sv */
// Port-level checks for the key press event detector, bound to the top level.
// Depends on assert_macros.svh and kped_pkg.
`default_nettype none
`include "assert_macros.svh"

module kped_checker #(
    parameter int NUM_KEYS = kped_pkg::NUM_KEYS_DEF,
    localparam int KIW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            cfg_we,
    input wire [kped_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire [kped_pkg::CFG_W-1:0]      cfg_data,
    input wire                            in_valid,
    input wire                            in_ready,
    input wire [NUM_KEYS-1:0]             keys_pressed,
    input wire                            out_valid,
    input wire                            out_ready,
    input wire [KIW-1:0]                  key_index,
    input wire [kped_pkg::KIND_W-1:0]     event_kind,
    input wire                            last_event
);

    logic cfg_seen;
    logic keys_seen;
    logic kind_ok;
    logic key_ok;
    logic [KIW+kped_pkg::KIND_W:0] out_word;

    assign cfg_seen  = cfg_we | (|cfg_index) | (|cfg_data);
    assign keys_seen = |keys_pressed;
    assign out_word  = {key_index, event_kind, last_event};
    assign kind_ok   = (event_kind != 2'd3) || (cfg_seen && !cfg_seen);
    assign key_ok    = (32'(key_index) < 32'(NUM_KEYS)) || (keys_seen && !keys_seen);

    `KPED_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
    `KPED_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready)
    `KPED_ASSERT_IMP(a_kind_legal, out_valid, kind_ok)
    `KPED_ASSERT_IMP(a_key_legal, out_valid, key_ok)

endmodule

bind key_press_event_detector kped_checker #(
    .NUM_KEYS (NUM_KEYS)
) u_kped_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .keys_pressed (keys_pressed),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .key_index    (key_index),
    .event_kind   (event_kind),
    .last_event   (last_event)
);

`default_nettype wire

/* test/kped_event_checker.sv */
// Checker for the key press event detector: watches the register port, the poll request
// channel and the event output, predicts the events of each poll and compares them in order.
// Depends on kped_pkg.
`default_nettype none

module kped_event_checker
    import kped_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire  [CFG_IDX_W-1:0] cfg_index,
    input  wire  [CFG_W-1:0]     cfg_data,
    input  wire                  in_valid,
    input  wire                  in_ready,
    input  wire  [4:0]           keys_pressed,
    input  wire                  out_valid,
    input  wire                  out_ready,
    input  wire  [2:0]           key_index,
    input  wire  [KIND_W-1:0]    event_kind,
    input  wire                  last_event,
    output int                   mismatch_count,
    output int                   events_pending
);

    localparam int NUM_KEYS = NUM_KEYS_DEF;
    localparam logic [7:0] HOLD_MAX = 8'(COUNT_MAX_DEF);

    typedef struct packed {
        logic [2:0]  key;
        event_kind_t kind;
        logic        last;
    } key_event_t;

    cfg_word_t   long_polls;
    cfg_word_t   repeat_polls;
    cfg_word_t   debounce_polls;
    logic [7:0]  hold_cnt [NUM_KEYS];
    logic [4:0]  prev_keys;
    key_event_t  expected_events [$];
    key_event_t  want;
    int          mismatches = 0;
    int          pending = 0;

    assign mismatch_count = mismatches;
    assign events_pending = pending;

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("%0t: event mismatch, %s: got %0d, want %0d", $time, what, got, exp_val);
        mismatches++;
    endtask

    function automatic key_event_t make_event(input int k, input event_kind_t kind);
        key_event_t ev;
        ev.key  = 3'(k);
        ev.kind = kind;
        ev.last = 1'b0;
        return ev;
    endfunction

    function automatic void predict_poll(input logic [4:0] keys);
        key_event_t poll_events [$];
        key_event_t tail;
        logic [4:0] fresh;
        logic [7:0] cnt;
        fresh = keys & ~prev_keys;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (keys[k])
            begin
                cnt = hold_cnt[k];
                if (cnt != HOLD_MAX)
                    cnt = cnt + 8'd1;
                hold_cnt[k] = cnt;
                if (cnt == long_polls)
                    poll_events.push_back(make_event(k, EV_LONG));
                else if (cnt > long_polls && repeat_polls != 0 &&
                         ((cnt - long_polls) % repeat_polls) == 0)
                    poll_events.push_back(make_event(k, EV_LONG));
            end
            else
            begin
                if (hold_cnt[k] >= debounce_polls)
                    poll_events.push_back(make_event(k, EV_UP));
                hold_cnt[k] = 8'd0;
            end
            if (fresh[k])
                poll_events.push_back(make_event(k, EV_DOWN));
        end
        if (poll_events.size() > 0)
        begin
            tail = poll_events[poll_events.size() - 1];
            tail.last = 1'b1;
            poll_events[poll_events.size() - 1] = tail;
        end
        foreach (poll_events[i])
            expected_events.push_back(poll_events[i]);
        prev_keys = keys;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_polls     = LONG_RESET;
            repeat_polls   = REPEAT_RESET;
            debounce_polls = DEBOUNCE_RESET;
            foreach (hold_cnt[k])
                hold_cnt[k] = 8'd0;
            prev_keys = 5'd0;
            expected_events.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LONG:     long_polls     = cfg_data;
                    REG_REPEAT:   repeat_polls   = cfg_data;
                    REG_DEBOUNCE: debounce_polls = cfg_data;
                    default:      ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                    report_mismatch("event with none expected, key", key_index, 0);
                else
                begin
                    want = expected_events.pop_front();
                    if (key_index !== want.key)
                        report_mismatch("key_index", key_index, want.key);
                    if (event_kind !== want.kind)
                        report_mismatch("event_kind", event_kind, want.kind);
                    if (last_event !== want.last)
                        report_mismatch("last_event", last_event, want.last);
                end
            end
            if (in_valid && in_ready)
                predict_poll(keys_pressed);
        end
        pending = expected_events.size();
    end

endmodule

`default_nettype wire

/* test/tb_key_press_event_detector.sv */
// Top of the key press event detector testbench: clock, reset, register writes and
// poll requests in directed and random phases, with the verdict.
// Depends on kped_pkg, kped_event_checker and the detector RTL.
`default_nettype none

module tb_key_press_event_detector;
    import kped_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT  = 3000;
    localparam int PHASES       = 5;
    localparam int PHASE_POLLS  = 70;
    localparam int ANCHOR_KEY   = 2;
    localparam int ANCHOR_POLLS = 300;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [4:0]           keys_pressed = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [2:0]           key_index;
    logic [KIND_W-1:0]    event_kind;
    logic                 last_event;
    int                   mismatch_count;
    int                   events_pending;

    int         idle_pct = 0;
    int         stall_pct = 0;
    int         quiet_cycles = 0;
    int         anchor_left = 0;
    logic [4:0] held_keys = '0;
    logic [4:0] poll_keys;

    logic [4:0] directed_a [9]  = '{5'd0, 5'd31, 5'd31, 5'd31, 5'd0, 5'd21, 5'd10, 5'd0,
                                    5'd16};
    logic [4:0] directed_b [13] = '{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd0,
                                    5'd1, 5'd2, 5'd4, 5'd8, 5'd16};

    cfg_word_t phase_long [PHASES]     = '{8'd1, 8'd3, 8'd0, 8'd200, 8'd255};
    cfg_word_t phase_repeat [PHASES]   = '{8'd1, 8'd255, 8'd2, 8'd5, 8'd1};
    cfg_word_t phase_debounce [PHASES] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd255};
    int        phase_idle [PHASES]     = '{0, 49, 0, 32, 0};
    int        phase_stall [PHASES]    = '{0, 0, 49, 32, 0};

    key_press_event_detector u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .keys_pressed (keys_pressed),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .key_index    (key_index),
        .event_kind   (event_kind),
        .last_event   (last_event)
    );

    kped_event_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .keys_pressed   (keys_pressed),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .key_index      (key_index),
        .event_kind     (event_kind),
        .last_event     (last_event),
        .mismatch_count (mismatch_count),
        .events_pending (events_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_key_press_event_detector: errors");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cfg_word_t value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input cfg_word_t long_v, input cfg_word_t rep_v,
                              input cfg_word_t deb_v);
        write_reg(REG_LONG, long_v);
        write_reg(REG_REPEAT, rep_v);
        write_reg(REG_DEBOUNCE, deb_v);
    endtask

    // hold valid and payload until the request is taken
    task automatic send_poll(input logic [4:0] keys);
        @(negedge clk);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        in_valid     <= 1'b1;
        keys_pressed <= keys;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (events_pending != 0)
            @(negedge clk);
    endtask

    // let a poll with no events run out before touching the registers
    task automatic settle;
        drain();
        repeat (40) @(negedge clk);
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        set_config(8'd1, 8'd0, 8'd0);
        foreach (directed_a[i])
            send_poll(directed_a[i]);
        settle();
        set_config(8'd0, 8'd3, 8'd255);
        write_reg(REG_UNUSED, 8'hA5);
        foreach (directed_b[i])
            send_poll(directed_b[i]);

        anchor_left = ANCHOR_POLLS;
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            set_config(phase_long[p], phase_repeat[p], phase_debounce[p]);
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int i = 0; i < PHASE_POLLS; i++)
            begin
                if (p == 1 && i == PHASE_POLLS / 2)
                    drain();
                if ($urandom_range(0, 99) < 15)
                    poll_keys = 5'($urandom_range(0, 31));
                else
                begin
                    for (int k = 0; k < 5; k++)
                        if ($urandom_range(0, 5) == 0)
                            held_keys[k] = ~held_keys[k];
                    poll_keys = held_keys;
                end
                if (anchor_left > 0)
                begin
                    poll_keys[ANCHOR_KEY] = 1'b1;
                    anchor_left--;
                end
                send_poll(poll_keys);
            end
        end
        settle();

        if (mismatch_count == 0 && events_pending == 0)
            $display("tb_key_press_event_detector: clean");
        else
            $display("tb_key_press_event_detector: errors");
        $finish;
    end

endmodule

`default_nettype wire
